FILE: src/assert_macros.svh
// Assertion macros shared by the RTL.
// Bodies expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked in the same cycle, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the next cycle, active during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/cli_pkg.sv
// Shared types and constants for the channel level idealizer.
// No dependencies.
`default_nettype none
package cli_pkg;
    localparam int MAX_FRAME_LEN = 8192;
    localparam int MAX_LEVEL     = 255;
    localparam int FIFO_DEPTH    = 4;
    localparam int DIV_STEPS     = 36;

    localparam logic [2:0] CFG_INIT_CC   = 3'd0;
    localparam logic [2:0] CFG_RUPTURE   = 3'd1;
    localparam logic [2:0] CFG_MIN_COUNT = 3'd2;
    localparam logic [2:0] CFG_AUTO_BASE = 3'd3;
    localparam logic [2:0] CFG_AUTO_COND = 3'd4;

    localparam logic signed [13:0] INIT_CC_RST = 14'sd2848;

    typedef struct packed {
        logic signed [19:0] y;
        logic               last;
        logic               rup;       // |y| beyond rupture level
        logic               in_range;  // |y| strictly inside rupture level
    } t_item;

    typedef struct packed {
        logic signed [8:0]  open_level;
        logic               level_valid;
        logic               frame_done;
        logic signed [8:0]  frame_max_level;
        logic               ruptured;
        logic               recovering;
        logic [13:0]        closed_count;
        logic signed [19:0] channel_current_now;
        logic signed [19:0] baseline_now;
    } t_result;
endpackage
`default_nettype wire

FILE: src/cli_front.sv
// Front end: accepts samples, classifies them against the rupture level
// and queues them for the back end. Uses cli_pkg.
`default_nettype none
module cli_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [19:0]   i_sample,
    input  wire logic          i_last,
    input  wire logic [18:0]   i_rupture,
    output cli_pkg::t_item     o_item,
    output logic               o_item_valid,
    input  wire logic          i_pop
);
    import cli_pkg::*;

    t_item      r_mem [FIFO_DEPTH];
    logic [1:0] r_wr, n_wr, r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;
    t_item      w_item;
    logic signed [20:0] w_y, w_rl;
    logic       w_push;

    assign w_y  = 21'(signed'(i_sample));
    assign w_rl = signed'({2'b00, i_rupture});

    always_comb begin
        w_item.y        = signed'(i_sample);
        w_item.last     = i_last;
        w_item.rup      = (w_y > w_rl) || (w_y < -w_rl);
        w_item.in_range = (w_y > -w_rl) && (w_y < w_rl);
    end

    assign o_ready      = (r_cnt != 3'(FIFO_DEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 3'd0);
    assign o_item       = r_mem[r_rd];

    always_comb begin
        n_wr  = w_push ? r_wr + 2'd1 : r_wr;
        n_rd  = i_pop ? r_rd + 2'd1 : r_rd;
        n_cnt = r_cnt + 3'(w_push) - 3'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end
endmodule
`default_nettype wire

FILE: src/cli_div.sv
// Restoring divider, one quotient bit per cycle, floor semantics for a
// signed dividend and a positive divisor. Uses cli_pkg.
`default_nettype none
module cli_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [35:0] i_dividend,
    input  wire logic [14:0]        i_divisor,
    output logic                    o_done,
    output logic signed [20:0]      o_quot
);
    import cli_pkg::*;

    logic        r_busy, n_busy, r_done, n_done, r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem, w_sh;
    logic [35:0] r_quo, n_quo;
    logic [14:0] r_div, n_div;
    logic        w_ge;
    logic [20:0] w_q;

    assign w_sh = {r_rem[14:0], r_quo[35]};
    assign w_ge = (w_sh >= {1'b0, r_div});
    assign w_q  = r_quo[20:0];
    // floor of a negative quotient: -q, or -q-1 with a remainder
    assign o_quot = r_neg ? signed'((r_rem == 16'd0) ? ~w_q + 21'd1 : ~w_q)
                          : signed'(w_q);
    assign o_done = r_done;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_dividend[35];
            n_quo  = i_dividend[35] ? unsigned'(-i_dividend) : unsigned'(i_dividend);
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = 6'(DIV_STEPS);
        end else if (r_busy) begin
            n_rem = w_ge ? w_sh - {1'b0, r_div} : w_sh;
            n_quo = {r_quo[34:0], w_ge};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end
endmodule
`default_nettype wire

FILE: src/cli_back.sv
// Back end: level tracking, frame end bookkeeping and baseline / channel
// current refinement, with the output register. Uses cli_pkg, cli_div.
`default_nettype none
module cli_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  cli_pkg::t_item          i_item,
    input  wire logic               i_item_valid,
    output logic                    o_pop,
    input  wire logic [13:0]        i_min_count,
    input  wire logic               i_auto_base,
    input  wire logic               i_auto_cond,
    input  wire logic               i_cc_load,
    input  wire logic signed [19:0] i_cc_value,
    output cli_pkg::t_result        o_res,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready
);
    import cli_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0,  S_MUL = 4'd1,  S_LVL = 4'd2,
                           S_END  = 4'd3,  S_Z0  = 4'd4,  S_Z1  = 4'd5,
                           S_ZDIV = 4'd6,  S_O0  = 4'd7,  S_O1  = 4'd8,
                           S_O2   = 4'd9,  S_O3  = 4'd10, S_ODIV = 4'd11,
                           S_EMIT = 4'd12;

    function automatic logic signed [19:0] sat20(input logic signed [22:0] v);
        if (v > 23'sd524287) return 20'sd524287;
        else if (v < -23'sd524288) return -20'sd524288;
        else return v[19:0];
    endfunction

    logic [3:0]         r_state, n_state;
    logic signed [19:0] r_y, n_y;
    logic               r_last, n_last, r_irup, n_irup, r_iin, n_iin;
    logic signed [8:0]  r_open, n_open, r_fmax, n_fmax, r_shown, n_shown;
    logic               r_valid, n_valid;
    logic signed [19:0] r_base, n_base, r_cc, n_cc;
    logic               r_rupf, n_rupf, r_recf, n_recf, r_pend, n_pend;
    logic [13:0]        r_zt, n_zt, r_ot, n_ot;
    logic signed [33:0] r_za, n_za, r_oa, n_oa;
    logic signed [34:0] r_prod, n_prod, r_prod2, n_prod2;
    logic signed [39:0] r_d, n_d, r_c3, n_c3, r_c5, n_c5;
    t_result            r_out, n_out;
    logic               r_ovalid, n_ovalid;

    logic signed [19:0] mul_a;
    logic signed [14:0] mul_b;
    logic signed [34:0] mul_p;
    logic [13:0]        w_need;
    logic signed [35:0] w_cc, w_up, w_dn, w_y4, w_p, w_s2;
    logic               w_go_up, w_go_dn, w_in0;
    logic signed [8:0]  w_lvl;
    logic               div_start, div_done;
    logic signed [35:0] div_num;
    logic [14:0]        div_den;
    logic signed [20:0] div_q;
    logic               w_emit;

    assign mul_p  = mul_a * mul_b;
    assign w_need = (i_min_count == 14'd0) ? 14'd1 : i_min_count;

    // staircase thresholds, everything scaled by four
    assign w_cc = 36'(r_cc);
    assign w_up = 36'(r_prod) + (w_cc <<< 1) + w_cc + (36'(r_base) <<< 2);
    assign w_dn = 36'(r_prod) - (w_cc <<< 1) - w_cc + (36'(r_base) <<< 2);
    assign w_y4 = 36'(r_y) <<< 2;
    assign w_go_up = (r_cc >= 0) ? (w_y4 > w_up) : (w_y4 < w_up);
    assign w_go_dn = (r_cc >= 0) ? (w_y4 < w_dn) : (w_y4 > w_dn);

    always_comb begin
        if (w_go_up) begin
            w_lvl = (r_open < 9'(MAX_LEVEL)) ? r_open + 9'sd1 : r_open;
        end else if (w_go_dn) begin
            w_lvl = (r_open <= 9'sd0) ? 9'sd0 : r_open - 9'sd1;
        end else begin
            w_lvl = r_open;
        end
    end

    // closed-level mean must lie within half a channel current of zero
    assign w_p  = 36'(r_prod);
    assign w_s2 = 36'(r_za) <<< 1;
    assign w_in0 = (r_cc > 0) ? ((-w_p < w_s2) && (w_s2 < w_p))
                              : ((w_p < w_s2) && (w_s2 < -w_p));

    assign w_emit = (r_state == S_EMIT) && (!r_ovalid || i_res_ready);

    cli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        logic signed [22:0] cc_sum;
        n_state = r_state;   n_y = r_y;         n_last = r_last;
        n_irup = r_irup;     n_iin = r_iin;     n_open = r_open;
        n_fmax = r_fmax;     n_shown = r_shown; n_valid = r_valid;
        n_base = r_base;     n_cc = r_cc;       n_rupf = r_rupf;
        n_recf = r_recf;     n_pend = r_pend;   n_zt = r_zt;
        n_ot = r_ot;         n_za = r_za;       n_oa = r_oa;
        n_prod = r_prod;     n_prod2 = r_prod2; n_d = r_d;
        n_c3 = r_c3;         n_c5 = r_c5;       n_out = r_out;
        n_ovalid = (r_ovalid && i_res_ready) ? 1'b0 : r_ovalid;
        o_pop = 1'b0;
        mul_a = r_cc;
        mul_b = 15'(signed'({r_open, 2'b00}));
        div_start = 1'b0;
        div_num = (36'(r_za) <<< 1) + 36'(signed'({1'b0, r_zt}));
        div_den = {r_zt, 1'b0};
        cc_sum = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop  = 1'b1;
                    n_y    = i_item.y;
                    n_last = i_item.last;
                    n_irup = i_item.rup;
                    n_iin  = i_item.in_range;
                    if (r_pend) begin
                        n_open = -9'sd1;
                        n_rupf = 1'b0;
                        n_recf = 1'b0;
                        n_pend = 1'b0;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_LVL;
            end
            S_LVL: begin
                n_shown = -9'sd1;
                n_valid = 1'b0;
                if (!r_rupf) begin
                    if (r_irup) begin
                        n_rupf = 1'b1;
                    end else begin
                        n_open  = w_lvl;
                        n_shown = w_lvl;
                        n_valid = 1'b1;
                        if (w_lvl > r_fmax) n_fmax = w_lvl;
                        if (w_lvl == 9'sd0 && r_zt < 14'(MAX_FRAME_LEN)) begin
                            n_zt = r_zt + 14'd1;
                            n_za = r_za + 34'(r_y);
                        end
                        if (w_lvl == 9'sd1 && r_ot < 14'(MAX_FRAME_LEN)) begin
                            n_ot = r_ot + 14'd1;
                            n_oa = r_oa + 34'(r_y);
                        end
                    end
                end
                n_state = r_last ? S_END : S_EMIT;
            end
            S_END: begin
                n_state = S_Z0;
                if (r_rupf) begin
                    n_recf  = r_iin;
                    n_state = S_EMIT;
                end else if (r_fmax >= 9'sd2 && r_open == 9'sd0) begin
                    // collapse from two or more open channels
                    n_rupf  = 1'b1;
                    n_recf  = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_Z0: begin
                mul_b = 15'({1'b0, r_zt});
                n_prod  = mul_p;
                n_state = (r_zt >= w_need) ? S_Z1 : S_O0;
            end
            S_Z1: begin
                if (w_in0) begin
                    div_start = 1'b1;
                    n_state   = S_ZDIV;
                end else begin
                    n_state = S_O0;
                end
            end
            S_ZDIV: begin
                if (div_done) begin
                    if (i_auto_cond) begin
                        cc_sum = 23'(r_cc) - 23'(div_q) + 23'(r_base);
                        n_cc = sat20(cc_sum);
                    end
                    if (i_auto_base) n_base = div_q[19:0];
                    n_state = S_O0;
                end
            end
            S_O0: begin
                mul_b   = 15'({1'b0, r_ot});
                n_prod  = mul_p;
                n_state = (i_auto_cond && r_ot >= w_need) ? S_O1 : S_EMIT;
            end
            S_O1: begin
                mul_a   = r_base;
                mul_b   = 15'({1'b0, r_ot});
                n_prod2 = mul_p;
                n_state = S_O2;
            end
            S_O2: begin
                n_d  = (40'(r_oa) <<< 2) - (40'(r_prod2) <<< 2);
                n_c3 = (40'(r_prod) <<< 1) + 40'(r_prod);
                n_c5 = (40'(r_prod) <<< 2) + 40'(r_prod);
                n_state = S_O3;
            end
            S_O3: begin
                // open-level mean within 0.75..1.25 channel currents
                div_num = (36'(r_oa) <<< 1) + 36'(signed'({1'b0, r_ot}));
                div_den = {r_ot, 1'b0};
                if ((r_cc > 0) ? ((r_c3 < r_d) && (r_d < r_c5))
                               : ((r_c5 < r_d) && (r_d < r_c3))) begin
                    div_start = 1'b1;
                    n_state   = S_ODIV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_ODIV: begin
                div_num = (36'(r_oa) <<< 1) + 36'(signed'({1'b0, r_ot}));
                div_den = {r_ot, 1'b0};
                if (div_done) begin
                    cc_sum  = 23'(div_q) - 23'(r_base);
                    n_cc    = sat20(cc_sum);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_ovalid                = 1'b1;
                    n_out.open_level        = r_shown;
                    n_out.level_valid       = r_valid;
                    n_out.frame_done        = r_last;
                    n_out.frame_max_level   = '0;
                    n_out.ruptured          = 1'b0;
                    n_out.recovering        = 1'b0;
                    n_out.closed_count      = '0;
                    n_out.channel_current_now = r_cc;
                    n_out.baseline_now      = r_base;
                    if (r_last) begin
                        n_out.frame_max_level = r_fmax;
                        n_out.ruptured        = r_rupf;
                        n_out.recovering      = r_recf;
                        n_out.closed_count    = r_rupf ? 14'd0 : r_zt;
                        n_pend = r_rupf;
                        n_fmax = -9'sd1;
                        n_zt   = '0;
                        n_za   = '0;
                        n_ot   = '0;
                        n_oa   = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cc_load) n_cc = i_cc_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= -9'sd1;
            r_fmax   <= -9'sd1;
            r_base   <= '0;
            r_cc     <= 20'(INIT_CC_RST);
            r_rupf   <= 1'b0;
            r_recf   <= 1'b0;
            r_pend   <= 1'b0;
            r_zt     <= '0;
            r_za     <= '0;
            r_ot     <= '0;
            r_oa     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_open   <= n_open;
            r_fmax   <= n_fmax;
            r_base   <= n_base;
            r_cc     <= n_cc;
            r_rupf   <= n_rupf;
            r_recf   <= n_recf;
            r_pend   <= n_pend;
            r_zt     <= n_zt;
            r_za     <= n_za;
            r_ot     <= n_ot;
            r_oa     <= n_oa;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y     <= n_y;
        r_last  <= n_last;
        r_irup  <= n_irup;
        r_iin   <= n_iin;
        r_shown <= n_shown;
        r_valid <= n_valid;
        r_prod  <= n_prod;
        r_prod2 <= n_prod2;
        r_d     <= n_d;
        r_c3    <= n_c3;
        r_c5    <= n_c5;
        r_out   <= n_out;
    end

    assign o_res       = r_out;
    assign o_res_valid = r_ovalid;
endmodule
`default_nettype wire

FILE: src/channel_level_idealizer.sv
// Top level of the channel level idealizer: configuration registers,
// front end queue and back end. Uses cli_pkg, cli_front, cli_back.
// Inside a frame each sample passes the states pop, multiply, level and emit;
// the next sample is popped after emit, which stalls while a result waits.
// Frame end adds up to two mean divisions, with their setup states, before emit.
// Reset (synchronous, active low) restores register defaults and level -1.
`default_nettype none
`include "assert_macros.svh"
module channel_level_idealizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [19:0] sample_current
    input  wire logic        i_s_tlast,   // frame_last
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [8:0] open_level, [9] level_valid, [18:10] frame_max_level,
    // [19] ruptured, [20] recovering, [34:21] closed_count,
    // [54:35] channel_current_now, [74:55] baseline_now
    output logic [79:0]      o_m_tdata,
    output logic             o_m_tlast,   // frame_done
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [18:0] i_cfg_data
);
    import cli_pkg::*;

    logic [13:0] r_init_cc;
    logic [18:0] r_rupture;
    logic [13:0] r_min_count;
    logic        r_auto_base, r_auto_cond;
    logic        r_cc_load;
    t_item       w_item;
    logic        w_item_valid, w_pop;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cc   <= INIT_CC_RST;
            r_rupture   <= 19'd32000;
            r_min_count <= 14'd500;
            r_auto_base <= 1'b1;
            r_auto_cond <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INIT_CC:   r_init_cc   <= i_cfg_data[13:0];
                CFG_RUPTURE:   r_rupture   <= i_cfg_data;
                CFG_MIN_COUNT: r_min_count <= i_cfg_data[13:0];
                CFG_AUTO_BASE: r_auto_base <= i_cfg_data[0];
                CFG_AUTO_COND: r_auto_cond <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // channel current reload is registered and follows the register write in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_load <= 1'b0;
        end else begin
            r_cc_load <= i_cfg_we && (i_cfg_idx == CFG_INIT_CC);
        end
    end

    cli_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_sample     (i_s_tdata[19:0]),
        .i_last       (i_s_tlast),
        .i_rupture    (r_rupture),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    cli_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .i_min_count  (r_min_count),
        .i_auto_base  (r_auto_base),
        .i_auto_cond  (r_auto_cond),
        .i_cc_load    (r_cc_load),
        .i_cc_value   (20'(signed'(r_init_cc))),
        .o_res        (w_res),
        .o_res_valid  (o_m_tvalid),
        .i_res_ready  (i_m_tready)
    );

    assign o_m_tlast = w_res.frame_done;
    assign o_m_tdata = {5'b0, w_res.baseline_now, w_res.channel_current_now,
                        w_res.closed_count, w_res.recovering, w_res.ruptured,
                        w_res.frame_max_level, w_res.level_valid, w_res.open_level};

    // a sample without a level always shows -1
    `ASSERT_IMPL(a_invalid_unknown, o_m_tvalid && !o_m_tdata[9], o_m_tdata[8:0] == 9'h1FF)
    // ruptured frames report no closed time
    `ASSERT_IMPL(a_rup_closed, o_m_tvalid && o_m_tdata[19], o_m_tdata[34:21] == 14'd0)
    // recovery is only flagged together with a rupture
    `ASSERT_IMPL(a_rec_rup, o_m_tvalid && o_m_tdata[20], o_m_tdata[19])
    `ASSERT_NEXT(a_rst_idle, !i_rst_n, !o_m_tvalid)
endmodule
`default_nettype wire
